[rtl/ippm_pkg.sv]
package ippm_pkg;

    localparam int COEF_W       = 32;
    localparam int QUOT_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int FRONT_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_UV            = 3'd0,
        REG_ROW1_UV            = 3'd1,
        REG_ROW2_UV            = 3'd2,
        REG_ROW_OFFSETS_01     = 3'd3,
        REG_ROW_OFFSET2_HEIGHT = 3'd4,
        REG_TRANSLATE_XY       = 3'd5
    } t_reg_idx;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef r00;
        t_coef r01;
        t_coef r10;
        t_coef r11;
        t_coef r20;
        t_coef r21;
        t_coef r02;
        t_coef r12;
        t_coef r22;
        t_coef t2;
        t_coef t0;
        t_coef t1;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic degen;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_tag;

endpackage

[rtl/ippm_cfg.sv]
module ippm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ippm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ippm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ippm_pkg::t_cfg                      o_cfg
);
    import ippm_pkg::*;

    logic [CFG_DATA_W-1:0] r_row0;
    logic [CFG_DATA_W-1:0] r_row1;
    logic [CFG_DATA_W-1:0] r_row2;
    logic [CFG_DATA_W-1:0] r_offs01;
    logic [CFG_DATA_W-1:0] r_offs2;
    logic [CFG_DATA_W-1:0] r_trans;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0   <= '0;
            r_row1   <= '0;
            r_row2   <= '0;
            r_offs01 <= '0;
            r_offs2  <= '0;
            r_trans  <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROW0_UV: begin
                    r_row0 <= i_cfg_data;
                end
                REG_ROW1_UV: begin
                    r_row1 <= i_cfg_data;
                end
                REG_ROW2_UV: begin
                    r_row2 <= i_cfg_data;
                end
                REG_ROW_OFFSETS_01: begin
                    r_offs01 <= i_cfg_data;
                end
                REG_ROW_OFFSET2_HEIGHT: begin
                    r_offs2 <= i_cfg_data;
                end
                REG_TRANSLATE_XY: begin
                    r_trans <= i_cfg_data;
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign o_cfg.r00 = r_row0[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.r01 = r_row0[COEF_W-1:0];
    assign o_cfg.r10 = r_row1[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.r11 = r_row1[COEF_W-1:0];
    assign o_cfg.r20 = r_row2[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.r21 = r_row2[COEF_W-1:0];
    assign o_cfg.r02 = r_offs01[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.r12 = r_offs01[COEF_W-1:0];
    assign o_cfg.r22 = r_offs2[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.t2  = r_offs2[COEF_W-1:0];
    assign o_cfg.t0  = r_trans[CFG_DATA_W-1 -: COEF_W];
    assign o_cfg.t1  = r_trans[COEF_W-1:0];

endmodule

[rtl/ippm_front.sv]
module ippm_front #(
    parameter int PIXEL_BITS = 11,
    parameter int M_W        = PIXEL_BITS + 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [PIXEL_BITS-1:0]            i_u,
    input  logic [PIXEL_BITS-1:0]            i_v,
    input  ippm_pkg::t_cfg                   i_cfg,
    output ippm_pkg::t_tag                   o_tag,
    output logic [M_W-1:0]                   o_dm,
    output logic [M_W-1:0]                   o_rem_x,
    output logic [M_W-1:0]                   o_rem_y,
    output logic [ippm_pkg::QUOT_W-1:0]      o_low_x,
    output logic [ippm_pkg::QUOT_W-1:0]      o_low_y
);
    import ippm_pkg::*;

    // a row product fits M_W magnitude bits, so sums need no extra growth
    localparam int A_W  = M_W + 1;
    localparam int HI_W = M_W - QUOT_W;
    localparam int P0_W = COEF_W + QUOT_W;
    localparam int P1_W = COEF_W + HI_W;
    localparam int P_W  = COEF_W + M_W;

    logic [PIXEL_BITS:0] u_ext;
    logic [PIXEL_BITS:0] v_ext;
    logic [COEF_W-1:0]   t_mag;
    logic                t2_pos;
    logic [M_W-1:0]      p_hi;
    t_tag                n_tag3;
    t_tag                n_tag6;

    // stage 1: row products
    logic                  r_v1;
    logic signed [A_W-1:0] r_m0u, r_m0v, r_m1u, r_m1v, r_m2u, r_m2v;
    // stage 2: rotated ray
    logic                  r_v2;
    logic signed [A_W-1:0] r_a0, r_a1, r_a2;
    // stage 3: magnitudes and signs
    t_tag                  r_tag3;
    logic [M_W-1:0]        r_am0, r_am1, r_dm3;
    // stage 4: partial products of height times ray
    t_tag                  r_tag4;
    logic [M_W-1:0]        r_dm4;
    logic [P0_W-1:0]       r_p0x, r_p0y;
    logic [P1_W-1:0]       r_p1x, r_p1y;
    // stage 5: full dividends
    t_tag                  r_tag5;
    logic [M_W-1:0]        r_dm5;
    logic [P_W-1:0]        r_px, r_py;
    // stage 6: quotient overflow check, division start
    t_tag                  r_tag6;
    logic [M_W-1:0]        r_dm6;
    logic [M_W-1:0]        r_rem_x, r_rem_y;
    logic [QUOT_W-1:0]     r_low_x, r_low_y;

    assign u_ext  = {1'b0, i_u};
    assign v_ext  = {1'b0, i_v};
    assign t_mag  = i_cfg.t2[COEF_W-1] ? COEF_W'(-i_cfg.t2) : COEF_W'(i_cfg.t2);
    assign t2_pos = !i_cfg.t2[COEF_W-1] && (i_cfg.t2 != '0);

    always_comb begin
        n_tag3       = '0;
        n_tag3.valid = r_v2;
        n_tag3.degen = (r_a2 == '0);
        n_tag3.neg_x = (t2_pos != r_a0[A_W-1]) != r_a2[A_W-1];
        n_tag3.neg_y = (t2_pos != r_a1[A_W-1]) != r_a2[A_W-1];
        n_tag6       = r_tag5;
        n_tag6.ovf_x = (r_px[P_W-1:QUOT_W] >= r_dm5);
        n_tag6.ovf_y = (r_py[P_W-1:QUOT_W] >= r_dm5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
            r_tag6 <= '0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_tag3 <= n_tag3;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
            r_tag6 <= n_tag6;
        end
    end

    assign p_hi = r_py[P_W-1:QUOT_W];

    always_ff @(posedge i_clk) begin
        r_m0u <= A_W'(i_cfg.r00) * A_W'($signed(u_ext));
        r_m0v <= A_W'(i_cfg.r01) * A_W'($signed(v_ext));
        r_m1u <= A_W'(i_cfg.r10) * A_W'($signed(u_ext));
        r_m1v <= A_W'(i_cfg.r11) * A_W'($signed(v_ext));
        r_m2u <= A_W'(i_cfg.r20) * A_W'($signed(u_ext));
        r_m2v <= A_W'(i_cfg.r21) * A_W'($signed(v_ext));

        r_a0 <= r_m0u + r_m0v + A_W'(i_cfg.r02);
        r_a1 <= r_m1u + r_m1v + A_W'(i_cfg.r12);
        r_a2 <= r_m2u + r_m2v + A_W'(i_cfg.r22);

        r_am0 <= r_a0[A_W-1] ? M_W'(-r_a0) : M_W'(r_a0);
        r_am1 <= r_a1[A_W-1] ? M_W'(-r_a1) : M_W'(r_a1);
        r_dm3 <= r_a2[A_W-1] ? M_W'(-r_a2) : M_W'(r_a2);

        r_dm4 <= r_dm3;
        r_p0x <= P0_W'(t_mag) * P0_W'(r_am0[QUOT_W-1:0]);
        r_p1x <= P1_W'(t_mag) * P1_W'(r_am0[M_W-1:QUOT_W]);
        r_p0y <= P0_W'(t_mag) * P0_W'(r_am1[QUOT_W-1:0]);
        r_p1y <= P1_W'(t_mag) * P1_W'(r_am1[M_W-1:QUOT_W]);

        r_dm5 <= r_dm4;
        r_px  <= P_W'(r_p0x) + {r_p1x, {QUOT_W{1'b0}}};
        r_py  <= P_W'(r_p0y) + {r_p1y, {QUOT_W{1'b0}}};

        r_dm6   <= r_dm5;
        r_rem_x <= r_px[P_W-1:QUOT_W];
        r_rem_y <= p_hi;
        r_low_x <= r_px[QUOT_W-1:0];
        r_low_y <= r_py[QUOT_W-1:0];
    end

    assign o_tag   = r_tag6;
    assign o_dm    = r_dm6;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_low_x = r_low_x;
    assign o_low_y = r_low_y;

endmodule

[rtl/ippm_div.sv]
module ippm_div #(
    parameter int M_W = 43
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ippm_pkg::t_tag                 i_tag,
    input  logic [M_W-1:0]                 i_dm,
    input  logic [M_W-1:0]                 i_rem_x,
    input  logic [M_W-1:0]                 i_rem_y,
    input  logic [ippm_pkg::QUOT_W-1:0]    i_low_x,
    input  logic [ippm_pkg::QUOT_W-1:0]    i_low_y,
    output ippm_pkg::t_tag                 o_tag,
    output logic [ippm_pkg::QUOT_W-1:0]    o_q_x,
    output logic [ippm_pkg::QUOT_W-1:0]    o_q_y
);
    import ippm_pkg::*;

    // one restoring step: the next dividend bit leaves the top of low,
    // the quotient bit enters at its bottom
    function automatic logic [M_W+QUOT_W-1:0] div_step(
        input logic [M_W-1:0]    rem,
        input logic [QUOT_W-1:0] low,
        input logic [M_W-1:0]    dm
    );
        logic [M_W:0] w;
        logic [M_W:0] diff;
        logic         ge;
        w    = {rem, low[QUOT_W-1]};
        diff = w - {1'b0, dm};
        ge   = (w >= {1'b0, dm});
        return {(ge ? diff[M_W-1:0] : w[M_W-1:0]), low[QUOT_W-2:0], ge};
    endfunction

    t_tag              r_tag   [QUOT_W];
    logic [M_W-1:0]    r_dm    [QUOT_W];
    logic [M_W-1:0]    r_rem_x [QUOT_W];
    logic [M_W-1:0]    r_rem_y [QUOT_W];
    logic [QUOT_W-1:0] r_low_x [QUOT_W];
    logic [QUOT_W-1:0] r_low_y [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++) begin : g_step
        t_tag              tag_in;
        logic [M_W-1:0]    dm_in;
        logic [M_W-1:0]    rem_x_in;
        logic [M_W-1:0]    rem_y_in;
        logic [QUOT_W-1:0] low_x_in;
        logic [QUOT_W-1:0] low_y_in;

        if (s == 0) begin : g_head
            assign tag_in   = i_tag;
            assign dm_in    = i_dm;
            assign rem_x_in = i_rem_x;
            assign rem_y_in = i_rem_y;
            assign low_x_in = i_low_x;
            assign low_y_in = i_low_y;
        end else begin : g_body
            assign tag_in   = r_tag[s-1];
            assign dm_in    = r_dm[s-1];
            assign rem_x_in = r_rem_x[s-1];
            assign rem_y_in = r_rem_y[s-1];
            assign low_x_in = r_low_x[s-1];
            assign low_y_in = r_low_y[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dm[s]                 <= dm_in;
            {r_rem_x[s], r_low_x[s]} <= div_step(rem_x_in, low_x_in, dm_in);
            {r_rem_y[s], r_low_y[s]} <= div_step(rem_y_in, low_y_in, dm_in);
        end
    end

    assign o_tag = r_tag[QUOT_W-1];
    assign o_q_x = r_low_x[QUOT_W-1];
    assign o_q_y = r_low_y[QUOT_W-1];

`ifndef ASSERT_OFF
    a_rem_x_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag[QUOT_W-1].valid && !r_tag[QUOT_W-1].degen && !r_tag[QUOT_W-1].ovf_x)
        |-> (r_rem_x[QUOT_W-1] < r_dm[QUOT_W-1]))
        else $error("x remainder not below divisor");

    a_rem_y_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag[QUOT_W-1].valid && !r_tag[QUOT_W-1].degen && !r_tag[QUOT_W-1].ovf_y)
        |-> (r_rem_y[QUOT_W-1] < r_dm[QUOT_W-1]))
        else $error("y remainder not below divisor");
`endif

endmodule

[rtl/pixel_to_ground_plane_projection.sv]
// pixel to ground plane projection
// input: a pixel (i_pixel_u, i_pixel_v) is taken at a rising edge where start
// is high and busy is low. busy is high only around reset, so a pixel can be
// taken on every clock
// config: i_cfg_index / i_cfg_data are written when i_cfg_valid and o_cfg_ready
// are both high; o_cfg_ready is always high. index 0..5 selects the rotation
// rows, offsets and translation, other indexes are dropped. write only while
// no pixel is in flight
// output: one result per pixel, o_result_valid high for one cycle with
// o_ground_x, o_ground_y and o_degenerate. there is no back pressure
// pipeline: the result transfer follows the pixel transfer through six front
// stages (products, sums, magnitudes, two for the wide product, overflow
// check), one stage per quotient bit of the 32-step restoring divider, and
// the output register
// throughput: one pixel per clock
// reset: synchronous, active low; clears the config, tag and valid registers
// to zero, sets busy and drops every pixel in flight
module pixel_to_ground_plane_projection #(
    parameter int PIXEL_BITS = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [PIXEL_BITS-1:0]               i_pixel_u,
    input  logic [PIXEL_BITS-1:0]               i_pixel_v,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ippm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ippm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_result_valid,
    output logic signed [ippm_pkg::COEF_W-1:0]  o_ground_x,
    output logic signed [ippm_pkg::COEF_W-1:0]  o_ground_y,
    output logic                                o_degenerate
);
    import ippm_pkg::*;

    localparam int M_W     = PIXEL_BITS + COEF_W;
    localparam int S_W     = QUOT_W + 3;
    localparam int LATENCY = FRONT_STAGES + QUOT_W + 1;

    // base +/- clamped quotient, saturated to the coefficient range
    function automatic t_coef project_sat(
        input t_coef             base,
        input logic [QUOT_W-1:0] q,
        input logic              ovf,
        input logic              neg
    );
        logic [QUOT_W:0]       q_clamp;
        logic signed [S_W-1:0] q_ext;
        logic signed [S_W-1:0] base_ext;
        logic signed [S_W-1:0] sum;
        t_coef                 res;
        q_clamp  = ovf ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, q};
        q_ext    = $signed({2'b00, q_clamp});
        base_ext = S_W'(base);
        sum      = neg ? (base_ext - q_ext) : (base_ext + q_ext);
        if (sum[S_W-1:COEF_W-1] == '0 || sum[S_W-1:COEF_W-1] == '1) begin
            res = sum[COEF_W-1:0];
        end else if (sum[S_W-1]) begin
            res = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COEF_W-1){1'b1}}};
        end
        return res;
    endfunction

    t_cfg              cfg;
    logic              accept;
    t_tag              front_tag;
    t_tag              div_tag;
    logic [M_W-1:0]    front_dm;
    logic [M_W-1:0]    front_rem_x;
    logic [M_W-1:0]    front_rem_y;
    logic [QUOT_W-1:0] front_low_x;
    logic [QUOT_W-1:0] front_low_y;
    logic [QUOT_W-1:0] q_x;
    logic [QUOT_W-1:0] q_y;

    logic  r_busy;
    logic  r_valid;
    t_coef r_gx;
    t_coef r_gy;
    logic  r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    ippm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ippm_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .M_W        (M_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_u     (i_pixel_u),
        .i_v     (i_pixel_v),
        .i_cfg   (cfg),
        .o_tag   (front_tag),
        .o_dm    (front_dm),
        .o_rem_x (front_rem_x),
        .o_rem_y (front_rem_y),
        .o_low_x (front_low_x),
        .o_low_y (front_low_y)
    );

    ippm_div #(
        .M_W (M_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (front_tag),
        .i_dm    (front_dm),
        .i_rem_x (front_rem_x),
        .i_rem_y (front_rem_y),
        .i_low_x (front_low_x),
        .i_low_y (front_low_y),
        .o_tag   (div_tag),
        .o_q_x   (q_x),
        .o_q_y   (q_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_tag.valid;
        end
    end

    // ray parallel to the ground: no crossing, report zeros
    always_ff @(posedge i_clk) begin
        r_degen <= div_tag.degen;
        if (div_tag.degen) begin
            r_gx <= '0;
            r_gy <= '0;
        end else begin
            r_gx <= project_sat(cfg.t0, q_x, div_tag.ovf_x, div_tag.neg_x);
            r_gy <= project_sat(cfg.t1, q_y, div_tag.ovf_y, div_tag.neg_y);
        end
    end

    assign o_result_valid = r_valid;
    assign o_ground_x     = r_gx;
    assign o_ground_y     = r_gy;
    assign o_degenerate   = r_degen;

`ifndef ASSERT_OFF
    a_result_follows_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_valid)
        else $error("pixel transfer without result");

    a_result_has_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LATENCY))
        else $error("result without pixel transfer");
`endif

endmodule

[dv/testbench.sv]
module testbench;
    import ippm_pkg::*;

    localparam int PIXEL_BITS  = 11;
    localparam int PIX_MAX     = (1 << PIXEL_BITS) - 1;
    localparam logic [PIXEL_BITS-1:0] PIX_ALL = '1;
    localparam int RANDOM_PIXELS = 1800;
    localparam int CALM_TAIL   = 250;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_SLACK = 60;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [127:0] QUOT_CAP = 128'd1 << 40;
    localparam longint signed Q_MAX = 64'sd2147483647;
    localparam longint signed Q_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_WRITE,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind                kind;
        logic [PIXEL_BITS-1:0]   u;
        logic [PIXEL_BITS-1:0]   v;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } t_bench_op;

    typedef struct {
        t_coef gx;
        t_coef gy;
        logic  degen;
    } t_ground_pt;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PIXEL_BITS-1:0]  i_pixel_u = '0;
    logic [PIXEL_BITS-1:0]  i_pixel_v = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_result_valid;
    t_coef                  o_ground_x;
    t_coef                  o_ground_y;
    logic                   o_degenerate;

    t_bench_op  op_q[$];
    t_ground_pt ground_q[$];
    t_cfg       stim_cfg = '0;
    t_cfg       live_cfg = '0;
    int         in_flight = 0;
    int         gap_left = 0;
    int         fail_count = 0;
    int         stall_cycles = 0;
    int         pixels_queued = 0;

    pixel_to_ground_plane_projection #(
        .PIXEL_BITS(PIXEL_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_pixel_u(i_pixel_u),
        .i_pixel_v(i_pixel_v),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_ground_x(o_ground_x),
        .o_ground_y(o_ground_y),
        .o_degenerate(o_degenerate)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_cfg cfg_apply(t_cfg c, logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] d);
        t_cfg n;
        n = c;
        case (idx)
            REG_ROW0_UV:            {n.r00, n.r01} = d;
            REG_ROW1_UV:            {n.r10, n.r11} = d;
            REG_ROW2_UV:            {n.r20, n.r21} = d;
            REG_ROW_OFFSETS_01:     {n.r02, n.r12} = d;
            REG_ROW_OFFSET2_HEIGHT: {n.r22, n.t2} = d;
            REG_TRANSLATE_XY:       {n.t0, n.t1} = d;
            default: ;
        endcase
        return n;
    endfunction

    function automatic logic [63:0] mag64(longint signed x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // base + trunc(-t2 * ray / depth), quotient capped, then clamped to 32 bits
    function automatic t_coef ground_coord(t_coef base, t_coef t2, longint signed ray,
                                           longint signed depth);
        logic [127:0]  num;
        logic [127:0]  quo;
        longint signed sum;
        logic          flip;
        num = {64'd0, mag64(t2)} * {64'd0, mag64(ray)};
        quo = num / {64'd0, mag64(depth)};
        if (quo >= QUOT_CAP)
            quo = QUOT_CAP;
        flip = ((t2 > 0) != (ray < 0)) != (depth < 0);
        sum = flip ? longint'(base) - longint'(quo[63:0])
                   : longint'(base) + longint'(quo[63:0]);
        if (sum > Q_MAX)
            return 32'sh7FFFFFFF;
        if (sum < Q_MIN)
            return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_ground_pt project_pixel(t_cfg c, logic [PIXEL_BITS-1:0] u,
                                                 logic [PIXEL_BITS-1:0] v);
        longint signed pu;
        longint signed pv;
        longint signed ray_x;
        longint signed ray_y;
        longint signed depth;
        t_ground_pt    pt;
        pu = longint'(u);
        pv = longint'(v);
        ray_x = longint'(c.r00) * pu + longint'(c.r01) * pv + longint'(c.r02);
        ray_y = longint'(c.r10) * pu + longint'(c.r11) * pv + longint'(c.r12);
        depth = longint'(c.r20) * pu + longint'(c.r21) * pv + longint'(c.r22);
        if (depth == 0) begin
            pt.gx = '0;
            pt.gy = '0;
            pt.degen = 1'b1;
        end else begin
            pt.gx = ground_coord(c.t0, c.t2, ray_x, depth);
            pt.gy = ground_coord(c.t1, c.t2, ray_y, depth);
            pt.degen = 1'b0;
        end
        return pt;
    endfunction

    task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_bench_op op;
        op.kind = OP_WRITE;
        op.u = '0;
        op.v = '0;
        op.idx = idx;
        op.data = data;
        op_q.push_back(op);
        stim_cfg = cfg_apply(stim_cfg, idx, data);
    endtask

    task automatic queue_pixel(logic [PIXEL_BITS-1:0] u, logic [PIXEL_BITS-1:0] v);
        t_bench_op op;
        op.kind = OP_PIXEL;
        op.u = u;
        op.v = v;
        op.idx = '0;
        op.data = '0;
        op_q.push_back(op);
        pixels_queued++;
    endtask

    task automatic queue_drain();
        t_bench_op op;
        op.kind = OP_DRAIN;
        op.u = '0;
        op.v = '0;
        op.idx = '0;
        op.data = '0;
        op_q.push_back(op);
    endtask

    function automatic t_coef rand_coef();
        int unsigned pick;
        int unsigned bits;
        t_coef       c;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: c = 32'sh7FFFFFFF;
                1: c = 32'sh80000000;
                2: c = 32'sh0;
                3: c = 32'sh1;
                default: c = -32'sh1;
            endcase
        end else if (pick == 1) begin
            c = $urandom;
        end else begin
            bits = $urandom_range(1, 20);
            c = t_coef'($urandom_range(0, (1 << bits) - 1));
            if ($urandom_range(0, 1) == 1)
                c = -c;
        end
        return c;
    endfunction

    function automatic t_coef tiny_coef(int unsigned span);
        return t_coef'(int'($urandom_range(0, 2 * span)) - int'(span));
    endfunction

    task automatic queue_random_setup();
        t_reg_idx    reg_order[6];
        int unsigned rot;
        bit          partial;
        bit          flat_depth;
        t_reg_idx    idx;
        reg_order = '{REG_ROW0_UV, REG_ROW1_UV, REG_ROW2_UV, REG_ROW_OFFSETS_01,
                      REG_ROW_OFFSET2_HEIGHT, REG_TRANSLATE_XY};
        rot = $urandom_range(0, 5);
        partial = ($urandom_range(0, 3) == 0);
        // small depth row so that pixels on the horizon line are easy to hit
        flat_depth = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < 6; k++) begin
            idx = reg_order[(k + rot) % 6];
            if (!partial || $urandom_range(0, 1) == 1) begin
                if (flat_depth && idx == REG_ROW2_UV)
                    queue_write(idx, {tiny_coef(4), tiny_coef(4)});
                else if (flat_depth && idx == REG_ROW_OFFSET2_HEIGHT)
                    queue_write(idx, {tiny_coef(4094), rand_coef()});
                else
                    queue_write(idx, {rand_coef(), rand_coef()});
            end
        end
        if ($urandom_range(0, 7) == 0)
            queue_write($urandom_range(0, 1) == 1 ? REG_SPARE_A : REG_SPARE_B,
                        {$urandom, $urandom});
    endtask

    task automatic queue_random_pixel();
        logic [PIXEL_BITS-1:0] u;
        logic [PIXEL_BITS-1:0] v;
        longint signed         rest;
        longint signed         row;
        u = PIXEL_BITS'($urandom_range(0, PIX_MAX));
        v = PIXEL_BITS'($urandom_range(0, PIX_MAX));
        if ($urandom_range(0, 15) == 0)
            u = ($urandom_range(0, 1) == 1) ? PIX_ALL : '0;
        if ($urandom_range(0, 15) == 0)
            v = ($urandom_range(0, 1) == 1) ? PIX_ALL : '0;
        // aim at the horizon line now and then: pick v so that the depth is zero
        if ($urandom_range(0, 4) == 0 && stim_cfg.r21 != 0) begin
            rest = -(longint'(stim_cfg.r20) * longint'(u) + longint'(stim_cfg.r22));
            if (rest % longint'(stim_cfg.r21) == 0) begin
                row = rest / longint'(stim_cfg.r21);
                if (row >= 0 && row <= PIX_MAX)
                    v = row[PIXEL_BITS-1:0];
            end
        end
        queue_pixel(u, v);
    endtask

    task automatic queue_directed();
        // registers still at reset: every ray is degenerate
        queue_pixel('0, '0);
        queue_pixel(PIX_ALL, PIX_ALL);
        queue_write(REG_SPARE_A, '1);
        queue_write(REG_SPARE_B, '1);
        queue_pixel(PIX_ALL, '0);

        // level camera, horizon at row 1000
        queue_write(REG_ROW0_UV,            {32'h00010000, 32'h00000000});
        queue_write(REG_ROW1_UV,            {32'h00000000, 32'h00010000});
        queue_write(REG_ROW2_UV,            {32'h00000000, 32'h00010000});
        queue_write(REG_ROW_OFFSETS_01,     {32'hFC000000, 32'h00000000});
        queue_write(REG_ROW_OFFSET2_HEIGHT, {32'hFC180000, 32'h00018000});
        queue_write(REG_TRANSLATE_XY,       {32'h00020000, 32'hFFFF0000});
        queue_pixel('0, '0);
        queue_pixel(PIX_ALL, '0);
        queue_pixel('0, PIX_ALL);
        queue_pixel(PIX_ALL, PIX_ALL);
        queue_pixel(PIXEL_BITS'(1024), PIXEL_BITS'(1000));
        queue_pixel(PIXEL_BITS'(5), PIXEL_BITS'(999));
        queue_pixel(PIXEL_BITS'(7), PIXEL_BITS'(1001));
        queue_drain();

        // largest coefficients: huge quotients, both clamps
        queue_write(REG_ROW0_UV,            {32'h7FFFFFFF, 32'h7FFFFFFF});
        queue_write(REG_ROW1_UV,            {32'h7FFFFFFF, 32'h7FFFFFFF});
        queue_write(REG_ROW2_UV,            {32'h7FFFFFFF, 32'h7FFFFFFF});
        queue_write(REG_ROW_OFFSETS_01,     {32'h7FFFFFFF, 32'h80000000});
        queue_write(REG_ROW_OFFSET2_HEIGHT, {32'h00000001, 32'h80000000});
        queue_write(REG_TRANSLATE_XY,       {32'h7FFFFFFF, 32'h80000000});
        queue_pixel('0, '0);
        queue_pixel(PIXEL_BITS'(1), '0);
        queue_pixel(PIX_ALL, PIX_ALL);

        // most negative coefficients
        queue_write(REG_ROW0_UV,            {32'h80000000, 32'h80000000});
        queue_write(REG_ROW1_UV,            {32'h80000000, 32'h80000000});
        queue_write(REG_ROW2_UV,            {32'h80000000, 32'h80000000});
        queue_write(REG_ROW_OFFSETS_01,     {32'h80000000, 32'h80000000});
        queue_write(REG_ROW_OFFSET2_HEIGHT, {32'h80000000, 32'h7FFFFFFF});
        queue_write(REG_TRANSLATE_XY,       {32'h00000000, 32'h00000000});
        queue_pixel(PIX_ALL, PIX_ALL);
        queue_pixel('0, PIX_ALL);
        queue_pixel(PIX_ALL, '0);

        // zero height: output is the translation where the depth u - v is nonzero
        queue_write(REG_ROW2_UV,            {32'h00000001, 32'hFFFFFFFF});
        queue_write(REG_ROW_OFFSET2_HEIGHT, {32'h00000000, 32'h00000000});
        queue_write(REG_TRANSLATE_XY,       {32'h12345678, 32'hEDCBA988});
        queue_pixel(PIXEL_BITS'(9), PIXEL_BITS'(9));
        queue_pixel(PIXEL_BITS'(10), PIXEL_BITS'(9));
    endtask

    // driver: pixels and register writes, with idle bursts
    always @(posedge i_clk) begin : drive_proc
        logic                  pix_xfer;
        logic                  cfg_xfer;
        logic                  nxt_start;
        logic                  nxt_cfg;
        logic                  launched;
        logic [PIXEL_BITS-1:0] nxt_u;
        logic [PIXEL_BITS-1:0] nxt_v;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        t_bench_op             op;
        pix_xfer = i_rst_n && start && !busy;
        cfg_xfer = i_rst_n && i_cfg_valid && o_cfg_ready;
        nxt_start = start && !pix_xfer;
        nxt_cfg = i_cfg_valid && !cfg_xfer;
        nxt_u = i_pixel_u;
        nxt_v = i_pixel_v;
        nxt_idx = i_cfg_index;
        nxt_data = i_cfg_data;
        launched = 1'b0;
        if (pix_xfer) begin
            ground_q.push_back(project_pixel(live_cfg, i_pixel_u, i_pixel_v));
            in_flight++;
        end
        if (i_rst_n && o_result_valid && in_flight > 0)
            in_flight--;
        if (cfg_xfer)
            live_cfg = cfg_apply(live_cfg, i_cfg_index, i_cfg_data);
        if (i_rst_n && !nxt_start && !nxt_cfg) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (op_q.size() != 0) begin
                case (op_q[0].kind)
                    OP_PIXEL: begin
                        op = op_q.pop_front();
                        nxt_start = 1'b1;
                        nxt_u = op.u;
                        nxt_v = op.v;
                        launched = 1'b1;
                    end
                    OP_WRITE: begin
                        // registers change only with no pixel in flight
                        if (in_flight == 0) begin
                            op = op_q.pop_front();
                            nxt_cfg = 1'b1;
                            nxt_idx = op.idx;
                            nxt_data = op.data;
                            launched = 1'b1;
                        end
                    end
                    default: begin
                        if (in_flight == 0)
                            void'(op_q.pop_front());
                    end
                endcase
                if (launched && op_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 12);
            end
        end
        start <= nxt_start;
        i_pixel_u <= nxt_u;
        i_pixel_v <= nxt_v;
        i_cfg_valid <= nxt_cfg;
        i_cfg_index <= nxt_idx;
        i_cfg_data <= nxt_data;
    end

    // monitor: every result against the oldest expected ground point
    always @(posedge i_clk) begin : check_proc
        t_ground_pt want;
        if (i_rst_n && o_result_valid) begin
            if (ground_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b", $time,
                         o_ground_x, o_ground_y, o_degenerate);
                fail_count++;
            end else begin
                want = ground_q.pop_front();
                if (o_ground_x !== want.gx) begin
                    $display("%0t: ground_x expected %0d got %0d", $time, want.gx,
                             o_ground_x);
                    fail_count++;
                end
                if (o_ground_y !== want.gy) begin
                    $display("%0t: ground_y expected %0d got %0d", $time, want.gy,
                             o_ground_y);
                    fail_count++;
                end
                if (o_degenerate !== want.degen) begin
                    $display("%0t: degenerate expected %0b got %0b", $time, want.degen,
                             o_degenerate);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("pixel_to_ground_plane_projection test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        queue_directed();
        while (pixels_queued < RANDOM_PIXELS) begin
            queue_random_setup();
            repeat ($urandom_range(20, 150)) begin
                queue_random_pixel();
                if ($urandom_range(0, 49) == 0)
                    queue_drain();
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_q.size() != 0 || start || i_cfg_valid || ground_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);

        if (fail_count == 0)
            $display("pixel_to_ground_plane_projection test passed");
        else
            $display("pixel_to_ground_plane_projection test failed");
        $finish;
    end

endmodule
